FILE: hdl/pic_pkg.sv
// Package for the priority interrupt controller.
// Holds action codes, field widths, the result beat type and the priority encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  localparam int ActionW   = 4;
  localparam int ValueW    = 8;
  localparam int WaitW     = 5;
  localparam int SrcW      = 5;
  localparam int SrcIdxW   = 3;
  localparam int DelayW    = 2;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 24;

  localparam logic [ActionW-1:0] ActRaise     = 4'd0;
  localparam logic [ActionW-1:0] ActWrFlags   = 4'd1;
  localparam logic [ActionW-1:0] ActWrMask    = 4'd2;
  localparam logic [ActionW-1:0] ActRdFlags   = 4'd3;
  localparam logic [ActionW-1:0] ActRdMask    = 4'd4;
  localparam logic [ActionW-1:0] ActEnable    = 4'd5;
  localparam logic [ActionW-1:0] ActDisable   = 4'd6;
  localparam logic [ActionW-1:0] ActHalt      = 4'd7;
  localparam logic [ActionW-1:0] ActCpuStep   = 4'd8;

  localparam logic [WaitW-1:0]  WaitReset     = 5'd20;
  localparam logic [DelayW-1:0] DelayStart    = 2'd2;
  localparam logic [DelayW-1:0] DelayLast     = 2'd1;
  localparam logic [DelayW-1:0] DelayIdle     = 2'd0;

  typedef struct packed {
    logic             stalled;
    logic             may_execute;
    logic [6:0]       vector;
    logic             take_interrupt;
    logic [ValueW-1:0] read_data;
  } result_t;

  // Index of the lowest set request bit; bit 0 has the highest priority.
  function automatic logic [SrcIdxW-1:0] pic_first(input logic [SrcW-1:0] req);
    logic [SrcIdxW-1:0] idx;
    idx = '0;
    for (int i = SrcW - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = SrcIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pic_core.sv
// Input register, controller state and per-beat result logic.
// Depends on pic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pic_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [pic_pkg::ActionW-1:0] in_action,
  input  wire logic [pic_pkg::ValueW-1:0]  in_value,
  input  wire logic                    cfg_we,
  input  wire logic [pic_pkg::WaitW-1:0]   cfg_wdata,
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output pic_pkg::result_t             res
);
  import pic_pkg::*;

  logic               held;
  logic [ActionW-1:0] action;
  logic [ValueW-1:0]  value;
  logic               advance;

  logic [ValueW-1:0]  pending, pending_next;
  logic [ValueW-1:0]  mask, mask_next;
  logic               master_en, master_en_next;
  logic [SrcW-1:0]    latch, latch_next;
  logic [DelayW-1:0]  delay, delay_next;
  logic               halted, halted_next;
  logic [WaitW-1:0]   wait_count, wait_count_next;
  logic [WaitW-1:0]   wait_steps;
  logic [SrcIdxW-1:0] src;

  assign advance   = held && res_ready;
  assign in_ready  = !held || res_ready;
  assign res_valid = held;
  assign src       = pic_first(latch);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      action <= in_action;
      value  <= in_value;
    end
  end

  always_comb begin
    pending_next    = pending;
    mask_next       = mask;
    master_en_next  = master_en;
    latch_next      = latch;
    delay_next      = delay;
    halted_next     = halted;
    wait_count_next = wait_count;
    res             = '0;
    unique case (action)
      ActRaise: begin
        pending_next = pending | value;
        halted_next  = 1'b0;
        if (master_en) begin
          latch_next = pending_next[SrcW-1:0] & mask[SrcW-1:0];
        end
      end
      ActWrFlags: begin
        pending_next = value;
        if (master_en) begin
          latch_next = value[SrcW-1:0] & mask[SrcW-1:0];
        end
      end
      ActWrMask: begin
        mask_next = value;
        if (master_en) begin
          latch_next = pending[SrcW-1:0] & value[SrcW-1:0];
        end
      end
      ActRdFlags: begin
        res.read_data = pending;
      end
      ActRdMask: begin
        res.read_data = mask;
      end
      ActEnable: begin
        delay_next = DelayStart;
      end
      ActDisable: begin
        master_en_next = 1'b0;
        latch_next     = '0;
        delay_next     = DelayIdle;
      end
      ActHalt: begin
        halted_next = 1'b1;
      end
      ActCpuStep: begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - WaitW'(1);
          res.stalled     = 1'b1;
        end else begin
          if (latch != '0) begin
            pending_next[src]  = 1'b0;
            res.vector         = {1'b1, src, 3'b000};
            res.take_interrupt = 1'b1;
            halted_next        = 1'b0;
            wait_count_next    = wait_steps;
            master_en_next     = 1'b0;
            latch_next         = '0;
          end
          if (delay == DelayStart) begin
            delay_next = DelayLast;
          end else if (delay == DelayLast) begin
            delay_next     = DelayIdle;
            master_en_next = 1'b1;
            latch_next     = pending_next[SrcW-1:0] & mask[SrcW-1:0];
          end
          res.may_execute = !halted_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      mask       <= '0;
      master_en  <= 1'b0;
      latch      <= '0;
      delay      <= DelayIdle;
      halted     <= 1'b0;
      wait_count <= '0;
      wait_steps <= WaitReset;
    end else begin
      if (cfg_we) begin
        wait_steps <= cfg_wdata;
      end
      if (advance) begin
        pending    <= pending_next;
        mask       <= mask_next;
        master_en  <= master_en_next;
        latch      <= latch_next;
        delay      <= delay_next;
        halted     <= halted_next;
        wait_count <= wait_count_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pic_out.sv
// Result register that decouples the core from the output stream.
// Depends on pic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pic_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_valid,
  output logic                  res_ready,
  input  wire pic_pkg::result_t res,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pic_pkg::result_t      out_res
);
  import pic_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/priority_interrupt_controller.sv
// Five-source fixed-priority interrupt controller, top level.
// Each accepted input beat is registered in pic_core; its result beat is registered again in pic_out.
// One beat per cycle while the output stream is ready; the core state updates once per beat.
// Reset (rst, synchronous): clears all flags, mask, latch, delay, wait; wait load is 20.
// Depends on pic_pkg, pic_core and pic_out.
`timescale 1ns / 1ps
`default_nettype none

module priority_interrupt_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // action[3:0], value[11:4], zero fill
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // read_data, take_interrupt, vector,
                                          // may_execute, stalled, zero fill
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);
  import pic_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  pic_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tdata[ActionW-1:0]),
    .in_value  (s_axis_tdata[ActionW+ValueW-1:ActionW]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pic_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, out_res};

`ifndef SYNTHESIS
  a_take_not_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_res.take_interrupt && out_res.stalled))
    else $error("interrupt taken on a stalled step");

  a_vector_only_on_take: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_res.vector != 7'd0) == out_res.take_interrupt))
    else $error("vector does not match take flag");

  a_stall_blocks_exec: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.stalled |-> !out_res.may_execute && out_res.read_data == '0)
    else $error("stalled step reports execution or read data");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result beat valid right after reset");
`endif

endmodule

`default_nettype wire
